>>> hw/rtl/shps_pkg.sv
// ----------------------------------------------------------------------------
// shps_pkg: shared types and constants for the heating program sequencer
// Command, status and phase codes, field widths and temperature limits.
// ----------------------------------------------------------------------------
package shps_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int TEMP_W   = 15;
  localparam int MS_W     = 16;
  localparam int SP_W     = 10;
  localparam int DUR_W    = 20;
  localparam int TOL_W    = 7;
  localparam int SEC_W    = 24;
  localparam int FRAC_W   = 10;
  localparam int ACC_W    = 17;  // fraction + elapsed_ms, below 66535
  localparam int CARRY_W  = 7;   // whole seconds carried out of one tick
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RESUME = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;

  // Status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_STATE = 2'd1;
  localparam logic [1:0] ST_BAD_ARG   = 2'd2;

  // Run phases
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_RUNNING = 2'd1;
  localparam logic [1:0] PH_PAUSED  = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SP1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SP2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SP3   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUR1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DUR2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DUR3  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd7;

  // Session temperature extremes start from the opposite ends
  localparam logic signed [TEMP_W-1:0] TEMP_LO_INIT = 15'sd9990;
  localparam logic signed [TEMP_W-1:0] TEMP_HI_INIT = -15'sd9990;

  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Millisecond accumulator split into whole seconds and remainder
  typedef struct packed {
    logic [CARRY_W-1:0] secs;
    logic [FRAC_W-1:0]  frac;
  } ms_split_t;

endpackage

>>> hw/rtl/shps_cmd_if.sv
// ----------------------------------------------------------------------------
// shps_cmd_if: command channel
// valid/ready channel carrying one command transaction.
// ----------------------------------------------------------------------------
interface shps_cmd_if;
  logic                                   valid;
  logic                                   ready;
  logic [shps_pkg::CMD_W-1:0]             command;
  logic signed [shps_pkg::TEMP_W-1:0]     temperature;
  logic [shps_pkg::MS_W-1:0]              elapsed_ms;

  modport source (output valid, command, temperature, elapsed_ms, input ready);
  modport sink   (input valid, command, temperature, elapsed_ms, output ready);
endinterface

>>> hw/rtl/shps_res_if.sv
// ----------------------------------------------------------------------------
// shps_res_if: result channel
// valid/ready channel carrying one status/result transaction.
// ----------------------------------------------------------------------------
interface shps_res_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [1:0]                         session_state;
  logic [1:0]                         active_stage;
  logic [shps_pkg::SP_W-1:0]          drive_setpoint;
  logic                               fan_on;
  logic                               cooling;
  logic [shps_pkg::SEC_W-1:0]         elapsed_s;
  logic [shps_pkg::SEC_W-1:0]         remaining_s;
  logic signed [shps_pkg::TEMP_W-1:0] min_temp;
  logic signed [shps_pkg::TEMP_W-1:0] max_temp;
  logic                               completed_pulse;
  logic                               aborted_pulse;

  modport source (output valid, status, session_state, active_stage, drive_setpoint, fan_on,
                  cooling, elapsed_s, remaining_s, min_temp, max_temp, completed_pulse,
                  aborted_pulse, input ready);
  modport sink   (input valid, status, session_state, active_stage, drive_setpoint, fan_on,
                  cooling, elapsed_s, remaining_s, min_temp, max_temp, completed_pulse,
                  aborted_pulse, output ready);
endinterface

>>> hw/rtl/shps_ms_split.sv
// ----------------------------------------------------------------------------
// shps_ms_split: millisecond accumulator to seconds
// Divides by 1000 through a reciprocal multiply and one correction step.
// ----------------------------------------------------------------------------
module shps_ms_split (
  input  logic [shps_pkg::ACC_W-1:0] acc_ms,
  output shps_pkg::ms_split_t        split
);
  import shps_pkg::*;

  // floor(2^20 / 1000): estimate is exact or one low over the whole range
  localparam int RECIP   = 1048;
  localparam int RSHIFT  = 20;
  localparam int PROD_W  = ACC_W + 11;

  logic [PROD_W-1:0]  prod;
  logic [CARRY_W-1:0] q_est;
  logic [ACC_W-1:0]   q_times;
  logic [ACC_W-1:0]   rem_est;

  always_comb begin
    prod    = {11'b0, acc_ms} * PROD_W'(RECIP);
    q_est   = prod[RSHIFT +: CARRY_W];
    // q_est * 1000 = q*1024 - q*16 - q*8
    q_times = (ACC_W'(q_est) << 10) - (ACC_W'(q_est) << 4) - (ACC_W'(q_est) << 3);
    rem_est = acc_ms - q_times;
    if (rem_est >= ACC_W'(MS_PER_S)) begin
      split.secs = q_est + CARRY_W'(1);
      split.frac = FRAC_W'(rem_est - ACC_W'(MS_PER_S));
    end else begin
      split.secs = q_est;
      split.frac = FRAC_W'(rem_est);
    end
  end
endmodule

>>> hw/rtl/staged_heating_program_sequencer.sv
// ----------------------------------------------------------------------------
// staged_heating_program_sequencer: three-stage heating program sequencer
// A command passes through the input register, then the result register;
// one transaction per cycle while the result register is free or being drained.
// Throughput is set by the single state-update stage, which retires one command
// per cycle whenever the result register is free or being drained.
// Reset (rst, synchronous, active high) returns to idle with cleared counters
// and the configuration registers at their default recipe.
// ----------------------------------------------------------------------------
module staged_heating_program_sequencer #(
  parameter int unsigned HUMIDITY_CAP_S = 86400
) (
  input  logic                             clk,
  input  logic                             rst,
  shps_cmd_if.sink                         cmd,
  shps_res_if.source                       result,
  input  logic                             cfg_wr_en,
  input  logic [shps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shps_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import shps_pkg::*;

  localparam logic [SEC_W-1:0] CAP_S = SEC_W'(HUMIDITY_CAP_S);
  localparam int EL_W    = SEC_W + 1;    // elapsed plus one tick's carry
  localparam int TOTAL_W = DUR_W + 2;
  localparam int THR_W   = SP_W + 2;     // signed setpoint minus tolerance

  // --------------------------------------------------------------------------
  // Configuration registers (recipe). Sampled into the session on start.
  // --------------------------------------------------------------------------
  logic [SP_W-1:0]  cfg_sp1, cfg_sp2, cfg_sp3;
  logic [DUR_W-1:0] cfg_dur1, cfg_dur2, cfg_dur3;
  logic             cfg_hold;
  logic [TOL_W-1:0] cfg_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_sp1  <= SP_W'(600);
      cfg_sp2  <= SP_W'(550);
      cfg_sp3  <= SP_W'(500);
      cfg_dur1 <= DUR_W'(7200);
      cfg_dur2 <= DUR_W'(10800);
      cfg_dur3 <= DUR_W'(7200);
      cfg_hold <= 1'b0;
      cfg_tol  <= TOL_W'(20);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SP1:  cfg_sp1  <= cfg_data[SP_W-1:0];
        REG_SP2:  cfg_sp2  <= cfg_data[SP_W-1:0];
        REG_SP3:  cfg_sp3  <= cfg_data[SP_W-1:0];
        REG_DUR1: cfg_dur1 <= cfg_data;
        REG_DUR2: cfg_dur2 <= cfg_data;
        REG_DUR3: cfg_dur3 <= cfg_data;
        REG_HOLD: cfg_hold <= cfg_data[0];
        REG_TOL:  cfg_tol  <= cfg_data[TOL_W-1:0];
        default:  ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The command stage drains it whenever the result register
  // is empty or being taken, so a new transaction can land every cycle.
  // --------------------------------------------------------------------------
  logic                     in_valid;
  logic [CMD_W-1:0]         in_command;
  logic signed [TEMP_W-1:0] in_temp;
  logic [MS_W-1:0]          in_ms;
  logic                     res_valid;
  logic                     advance;

  assign advance   = in_valid && (!res_valid || result.ready);
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_command <= cmd.command;
      in_temp    <= cmd.temperature;
      in_ms      <= cmd.elapsed_ms;
    end
  end

  // --------------------------------------------------------------------------
  // Session state. Program mode is implied by a non-idle phase.
  // --------------------------------------------------------------------------
  logic [1:0]               phase, phase_next;
  logic [1:0]               stage_idx, stage_idx_next;
  logic                     warmed_up, warmed_up_next;
  logic [SEC_W-1:0]         secs, secs_next;
  logic [SEC_W-1:0]         secs_left, secs_left_next;
  logic [FRAC_W-1:0]        ms_frac, ms_frac_next;
  logic signed [TEMP_W-1:0] lo_temp, lo_temp_next;
  logic signed [TEMP_W-1:0] hi_temp, hi_temp_next;
  logic [SP_W-1:0]          setpoint, setpoint_next;
  logic                     fan, fan_next;
  logic                     cool, cool_next;

  // Session copy of the recipe, with cumulative stage boundaries precomputed
  logic [SP_W-1:0]    s_sp0, s_sp1, s_sp2;
  logic [DUR_W-1:0]   s_cum1;
  logic [DUR_W:0]     s_cum2;
  logic [TOTAL_W-1:0] s_total;
  logic               s_hold;
  logic [TOL_W-1:0]   s_tol;

  logic [DUR_W:0]     cfg_cum2;
  logic [TOTAL_W-1:0] cfg_total;
  logic               start_ok;

  assign cfg_cum2  = {1'b0, cfg_dur1} + {1'b0, cfg_dur2};
  assign cfg_total = {1'b0, cfg_cum2} + TOTAL_W'(cfg_dur3);
  assign start_ok  = advance && (in_command == CMD_START) && (cfg_total != '0);

  always_ff @(posedge clk) begin
    if (start_ok) begin
      s_sp0   <= cfg_sp1;
      s_sp1   <= cfg_sp2;
      s_sp2   <= cfg_sp3;
      s_cum1  <= cfg_dur1;
      s_cum2  <= cfg_cum2;
      s_total <= cfg_total;
      s_hold  <= cfg_hold;
      s_tol   <= cfg_tol;
    end
  end

  // --------------------------------------------------------------------------
  // Tick datapath: warm-up test, ms accumulation, stage select, end check
  // --------------------------------------------------------------------------
  logic signed [THR_W-1:0] warm_thr;
  logic                    warm_hit;
  logic [ACC_W-1:0]        acc_ms;
  ms_split_t               split;
  logic [EL_W-1:0]         el;
  logic [1:0]              el_stage;
  logic [EL_W-1:0]         limit;
  logic [SP_W-1:0]         el_sp;
  logic [SP_W-1:0]         resume_sp;

  // Warm-up always compares against the first stage setpoint; the threshold is
  // sign-extended to the full sample width so no sample bits are dropped
  assign warm_thr = $signed({2'b0, s_sp0}) - $signed({{(THR_W-TOL_W){1'b0}}, s_tol});
  assign warm_hit = in_temp >= TEMP_W'(warm_thr);

  assign acc_ms = {{(ACC_W-FRAC_W){1'b0}}, ms_frac} + {1'b0, in_ms};

  shps_ms_split u_ms_split (
    .acc_ms (acc_ms),
    .split  (split)
  );

  assign el    = {1'b0, secs} + EL_W'(split.secs);
  assign limit = s_hold ? {1'b0, CAP_S} : EL_W'(s_total);

  // Stage from cumulative boundaries; past the recipe end the last stage holds
  always_comb begin
    priority if (el < EL_W'(s_cum1)) begin
      el_stage = 2'd0;
    end else if (el < EL_W'(s_cum2)) begin
      el_stage = 2'd1;
    end else begin
      el_stage = 2'd2;
    end
  end

  always_comb begin
    unique case (el_stage)
      2'd0:    el_sp = s_sp0;
      2'd1:    el_sp = s_sp1;
      default: el_sp = s_sp2;
    endcase
    unique case (stage_idx)
      2'd0:    resume_sp = s_sp0;
      2'd1:    resume_sp = s_sp1;
      default: resume_sp = s_sp2;
    endcase
  end

  // --------------------------------------------------------------------------
  // Command decode and next state
  // --------------------------------------------------------------------------
  logic [1:0] status_c;
  logic       done_c, abort_c;

  always_comb begin
    phase_next     = phase;
    stage_idx_next = stage_idx;
    warmed_up_next = warmed_up;
    secs_next      = secs;
    secs_left_next = secs_left;
    ms_frac_next   = ms_frac;
    lo_temp_next   = lo_temp;
    hi_temp_next   = hi_temp;
    setpoint_next  = setpoint;
    fan_next       = fan;
    cool_next      = cool;
    status_c       = ST_OK;
    done_c         = 1'b0;
    abort_c        = 1'b0;

    unique case (in_command)
      CMD_TICK: begin
        // ticks outside a running session are ignored
        if (phase == PH_RUNNING) begin
          if (in_temp < lo_temp) lo_temp_next = in_temp;
          if (in_temp > hi_temp) hi_temp_next = in_temp;
          if (warmed_up || warm_hit) begin
            warmed_up_next = 1'b1;
            ms_frac_next   = split.frac;
            if (el >= limit) begin
              phase_next     = PH_DONE;
              secs_next      = limit[SEC_W-1:0];
              secs_left_next = '0;
              setpoint_next  = '0;
              fan_next       = 1'b1;
              cool_next      = 1'b1;
              done_c         = 1'b1;
            end else begin
              secs_next      = el[SEC_W-1:0];
              stage_idx_next = el_stage;
              setpoint_next  = el_sp;
              if (s_hold && (el >= EL_W'(s_total))) begin
                secs_left_next = '0;
              end else begin
                secs_left_next = SEC_W'(EL_W'(s_total) - el);
              end
            end
          end
        end
      end
      CMD_START: begin
        if (cfg_total == '0) begin
          status_c = ST_BAD_ARG;
        end else begin
          phase_next     = PH_RUNNING;
          stage_idx_next = 2'd0;
          secs_next      = '0;
          secs_left_next = SEC_W'(cfg_total);
          ms_frac_next   = '0;
          setpoint_next  = cfg_sp1;
          fan_next       = 1'b1;
          cool_next      = 1'b0;
          lo_temp_next   = TEMP_LO_INIT;
          hi_temp_next   = TEMP_HI_INIT;
          warmed_up_next = 1'b0;
        end
      end
      CMD_PAUSE: begin
        if (phase != PH_RUNNING) begin
          status_c = ST_BAD_STATE;
        end else begin
          phase_next    = PH_PAUSED;
          setpoint_next = '0;
          fan_next      = 1'b0;
        end
      end
      CMD_RESUME: begin
        if (phase != PH_PAUSED) begin
          status_c = ST_BAD_STATE;
        end else begin
          phase_next    = PH_RUNNING;
          setpoint_next = resume_sp;
          fan_next      = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase == PH_IDLE) begin
          status_c = ST_BAD_STATE;
        end else begin
          abort_c       = (phase == PH_RUNNING) || (phase == PH_PAUSED);
          phase_next    = PH_IDLE;
          setpoint_next = '0;
          fan_next      = 1'b0;
          cool_next     = 1'b0;
        end
      end
      default: begin
        status_c = ST_BAD_ARG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      stage_idx <= 2'd0;
      warmed_up <= 1'b0;
      secs      <= '0;
      secs_left <= '0;
      ms_frac   <= '0;
      lo_temp   <= TEMP_LO_INIT;
      hi_temp   <= TEMP_HI_INIT;
      setpoint  <= '0;
      fan       <= 1'b0;
      cool      <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      stage_idx <= stage_idx_next;
      warmed_up <= warmed_up_next;
      secs      <= secs_next;
      secs_left <= secs_left_next;
      ms_frac   <= ms_frac_next;
      lo_temp   <= lo_temp_next;
      hi_temp   <= hi_temp_next;
      setpoint  <= setpoint_next;
      fan       <= fan_next;
      cool      <= cool_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register: holds a finished transaction while the sink stalls
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.status          <= status_c;
      result.session_state   <= phase_next;
      result.active_stage    <= stage_idx_next;
      result.drive_setpoint  <= setpoint_next;
      result.fan_on          <= fan_next;
      result.cooling         <= cool_next;
      result.elapsed_s       <= secs_next;
      result.remaining_s     <= secs_left_next;
      result.min_temp        <= lo_temp_next;
      result.max_temp        <= hi_temp_next;
      result.completed_pulse <= done_c;
      result.aborted_pulse   <= abort_c;
    end
  end

  assign result.valid = res_valid;

endmodule
